### sv/pci_pkg.sv
// Shared constants, codes and types of the pressure curve interpolator.
package pci_pkg;

   localparam int MAX_POINTS_DEF = 7;
   localparam int REG_SLOTS      = 7;

   localparam int SAMPLE_W    = 16;
   localparam int POINT_W     = 2 * SAMPLE_W;
   localparam int COUNT_W     = 3;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   // signed product of two 17-bit differences, and its magnitude
   localparam int PROD_W = 34;
   localparam int MAG_W  = 32;

   // quotient bits resolved per divider stage
   localparam int DIV_BITS   = 2;
   localparam int DIV_STAGES = MAG_W / DIV_BITS;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_POINT_COUNT = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_POINT_BASE  = 3'd1;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 3'd5;
   localparam logic [COUNT_W-1:0] COUNT_MIN   = 3'd2;

   localparam logic [POINT_W-1:0] POINT_RESET [REG_SLOTS] = '{
      32'h0000_0000, 32'h4000_4000, 32'h8000_8000, 32'hBFFF_BFFF,
      32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF
   };

   typedef logic [SAMPLE_W-1:0] sample_type;
   typedef logic [POINT_W-1:0]  point_type;

endpackage

### sv/pressure_curve_interpolator.sv
// Top level of the pressure curve interpolator: piecewise-linear pressure mapping pipeline.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+-------------------------------------------
//  req     | in  | req_tvalid/req_tready | req_tdata[15:0] raw_pressure
//  rsp     | out | rsp_tvalid/rsp_tready | rsp_tdata[15:0] curved_pressure
//  csr     | in  | csr_valid/csr_ready   | csr_index[2:0] register, csr_data[31:0] value
//
// One sample per cycle while the skid register is empty; from req transfer to rsp_tvalid
// each sample passes segment select, differences, multiply, magnitude, 16 divider stages
// (2 quotient bits each, set by the 32-bit quotient width), then the add/saturate stage.
// Synchronous active-high reset clears all valid bits and loads the curve registers with
// their defaults. When rsp stalls, the result in the output register moves into a skid
// register and the pipeline freezes while it is full; nothing is lost. csr_ready is always
// high; users must change registers only while the block is idle, which is not enforced.
module pressure_curve_interpolator
   import pci_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // input samples
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [SAMPLE_W-1:0]    req_tdata,   // [15:0] raw_pressure
   // mapped samples
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [SAMPLE_W-1:0]    rsp_tdata,   // [15:0] curved_pressure
   // register writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [COUNT_W-1:0] count_ff, count_in;
   point_type          point_ff [MAX_POINTS];
   point_type          point_in [MAX_POINTS];
   logic               csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      count_in = count_ff;
      if (csr_write && csr_index == REG_POINT_COUNT) begin
         count_in = csr_data[COUNT_W-1:0];
      end
      for (int i = 0; i < MAX_POINTS; i++) begin
         point_in[i] = point_ff[i];
         // indexes of breakpoints beyond MAX_POINTS are never read, so writes drop
         if (csr_write && csr_index == REG_POINT_BASE + CSR_INDEX_W'(i)) begin
            point_in[i] = csr_data[POINT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_RESET;
         for (int i = 0; i < MAX_POINTS; i++) begin
            point_ff[i] <= POINT_RESET[i];
         end
      end else begin
         count_ff <= count_in;
         point_ff <= point_in;
      end
   end

   // count clamped to 2..MAX_POINTS
   logic [COUNT_W-1:0] used_count;

   always_comb begin
      if (count_ff < COUNT_MIN) begin
         used_count = COUNT_MIN;
      end else if (count_ff > COUNT_W'(MAX_POINTS)) begin
         used_count = COUNT_W'(MAX_POINTS);
      end else begin
         used_count = count_ff;
      end
   end

   // ------------------------------------------------------------------
   // Flow control: global advance, skid register at the output
   // ------------------------------------------------------------------
   logic       adv;
   logic       skid_valid_ff, skid_valid_in;
   sample_type skid_y_ff, skid_y_in;
   logic       out_valid_ff, out_valid_in;
   sample_type out_y_ff, out_y_in;

   assign adv        = !skid_valid_ff;
   assign req_tready = adv;
   assign rsp_tvalid = skid_valid_ff || out_valid_ff;
   assign rsp_tdata  = skid_valid_ff ? skid_y_ff : out_y_ff;

   always_comb begin
      if (skid_valid_ff) begin
         skid_valid_in = !rsp_tready;
         skid_y_in     = skid_y_ff;
      end else begin
         // pipeline moves on; an untaken result parks in the skid register
         skid_valid_in = out_valid_ff && !rsp_tready;
         skid_y_in     = out_y_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: segment select
   // ------------------------------------------------------------------
   logic       s1_valid_ff;
   sample_type s1_p_ff, s1_xa_ff, s1_ya_ff, s1_xb_ff, s1_yb_ff;
   sample_type sel_xa, sel_ya, sel_xb, sel_yb;

   always_comb begin
      // beyond the last breakpoint: flat segment on its y, so the product is zero
      sel_xa = '0;
      sel_ya = '0;
      sel_xb = '0;
      sel_yb = '0;
      for (int i = 0; i < MAX_POINTS; i++) begin
         if (COUNT_W'(i) == used_count - COUNT_W'(1)) begin
            sel_xa = point_ff[i][POINT_W-1:SAMPLE_W];
            sel_xb = point_ff[i][POINT_W-1:SAMPLE_W];
            sel_ya = point_ff[i][SAMPLE_W-1:0];
            sel_yb = point_ff[i][SAMPLE_W-1:0];
         end
      end
      // descending scan, so the lowest matching breakpoint wins
      for (int i = MAX_POINTS - 1; i >= 1; i--) begin
         if (COUNT_W'(i) < used_count && req_tdata <= point_ff[i][POINT_W-1:SAMPLE_W]) begin
            sel_xa = point_ff[i-1][POINT_W-1:SAMPLE_W];
            sel_ya = point_ff[i-1][SAMPLE_W-1:0];
            sel_xb = point_ff[i][POINT_W-1:SAMPLE_W];
            sel_yb = point_ff[i][SAMPLE_W-1:0];
         end
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: differences and span
   // ------------------------------------------------------------------
   logic                       s2_valid_ff, s2_valid_in;
   logic signed [SAMPLE_W:0]   s2_dy_ff, s2_dy_in;
   logic signed [SAMPLE_W:0]   s2_dp_ff, s2_dp_in;
   sample_type                 s2_span_ff, s2_span_in;
   sample_type                 s2_ya_ff;
   logic        [SAMPLE_W:0]   span_full;

   assign s2_valid_in = s1_valid_ff;
   assign s2_dy_in    = {1'b0, s1_yb_ff} - {1'b0, s1_ya_ff};
   assign s2_dp_in    = {1'b0, s1_p_ff} - {1'b0, s1_xa_ff};
   assign span_full   = {1'b0, s1_xb_ff} - {1'b0, s1_xa_ff};

   // zero or negative span floors to one
   always_comb begin
      if (span_full[SAMPLE_W] || span_full == '0) begin
         s2_span_in = sample_type'(1);
      end else begin
         s2_span_in = span_full[SAMPLE_W-1:0];
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: signed product
   // ------------------------------------------------------------------
   logic                     s3_valid_ff, s3_valid_in;
   logic signed [PROD_W-1:0] s3_prod_ff, s3_prod_in;
   sample_type               s3_span_ff, s3_ya_ff;

   assign s3_valid_in = s2_valid_ff;
   assign s3_prod_in  = s2_dy_ff * s2_dp_ff;

   // ------------------------------------------------------------------
   // Stage 4 and divider: magnitude, then 16 restoring stages
   // ------------------------------------------------------------------
   logic             div_valid_ff [DIV_STAGES+1];
   logic [MAG_W-1:0] div_nq_ff    [DIV_STAGES+1];   // dividend shifts out, quotient in
   logic [MAG_W-1:0] div_nq_in    [DIV_STAGES+1];
   sample_type       div_rem_ff   [DIV_STAGES+1];
   sample_type       div_rem_in   [DIV_STAGES+1];
   sample_type       div_span_ff  [DIV_STAGES+1];
   sample_type       div_ya_ff    [DIV_STAGES+1];
   logic             div_neg_ff   [DIV_STAGES+1];

   logic [SAMPLE_W:0] trial;
   sample_type        rem_w;
   logic [MAG_W-1:0]  nq_w;

   always_comb begin
      div_nq_in[0]  = s3_prod_ff[PROD_W-1] ? MAG_W'(-s3_prod_ff) : MAG_W'(s3_prod_ff);
      div_rem_in[0] = '0;
      trial = '0;
      rem_w = '0;
      nq_w  = '0;
      for (int k = 0; k < DIV_STAGES; k++) begin
         rem_w = div_rem_ff[k];
         nq_w  = div_nq_ff[k];
         for (int j = 0; j < DIV_BITS; j++) begin
            trial = {rem_w, nq_w[MAG_W-1]};
            nq_w  = {nq_w[MAG_W-2:0], 1'b0};
            if (trial >= {1'b0, div_span_ff[k]}) begin
               trial   = trial - {1'b0, div_span_ff[k]};
               nq_w[0] = 1'b1;
            end
            rem_w = trial[SAMPLE_W-1:0];
         end
         div_rem_in[k+1] = rem_w;
         div_nq_in[k+1]  = nq_w;
      end
   end

   // ------------------------------------------------------------------
   // Final stage: signed quotient plus y_a, saturate
   // ------------------------------------------------------------------
   logic [PROD_W-1:0] q_ext, ya_ext, y_sum;

   assign q_ext  = {{(PROD_W-MAG_W){1'b0}}, div_nq_ff[DIV_STAGES]};
   assign ya_ext = {{(PROD_W-SAMPLE_W){1'b0}}, div_ya_ff[DIV_STAGES]};
   assign y_sum  = div_neg_ff[DIV_STAGES] ? ya_ext - q_ext : ya_ext + q_ext;

   assign out_valid_in = div_valid_ff[DIV_STAGES];

   always_comb begin
      if (y_sum[PROD_W-1]) begin
         out_y_in = '0;
      end else if (y_sum[PROD_W-2:SAMPLE_W] != '0) begin
         out_y_in = '1;
      end else begin
         out_y_in = y_sum[SAMPLE_W-1:0];
      end
   end

   // ------------------------------------------------------------------
   // Pipeline registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         s3_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
         for (int k = 0; k <= DIV_STAGES; k++) begin
            div_valid_ff[k] <= 1'b0;
         end
      end else begin
         skid_valid_ff <= skid_valid_in;
         if (adv) begin
            s1_valid_ff     <= req_tvalid;
            s2_valid_ff     <= s2_valid_in;
            s3_valid_ff     <= s3_valid_in;
            div_valid_ff[0] <= s3_valid_ff;
            for (int k = 1; k <= DIV_STAGES; k++) begin
               div_valid_ff[k] <= div_valid_ff[k-1];
            end
            out_valid_ff <= out_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      skid_y_ff <= skid_y_in;
      if (adv) begin
         s1_p_ff  <= req_tdata;
         s1_xa_ff <= sel_xa;
         s1_ya_ff <= sel_ya;
         s1_xb_ff <= sel_xb;
         s1_yb_ff <= sel_yb;

         s2_dy_ff   <= s2_dy_in;
         s2_dp_ff   <= s2_dp_in;
         s2_span_ff <= s2_span_in;
         s2_ya_ff   <= s1_ya_ff;

         s3_prod_ff <= s3_prod_in;
         s3_span_ff <= s2_span_ff;
         s3_ya_ff   <= s2_ya_ff;

         div_nq_ff[0]   <= div_nq_in[0];
         div_rem_ff[0]  <= div_rem_in[0];
         div_span_ff[0] <= s3_span_ff;
         div_ya_ff[0]   <= s3_ya_ff;
         div_neg_ff[0]  <= s3_prod_ff[PROD_W-1];
         for (int k = 1; k <= DIV_STAGES; k++) begin
            div_nq_ff[k]   <= div_nq_in[k];
            div_rem_ff[k]  <= div_rem_in[k];
            div_span_ff[k] <= div_span_ff[k-1];
            div_ya_ff[k]   <= div_ya_ff[k-1];
            div_neg_ff[k]  <= div_neg_ff[k-1];
         end

         out_y_ff <= out_y_in;
      end
   end

endmodule

### sv/pci_checker.sv
// Port-level assertions for the pressure curve interpolator and their bind.
module pci_checker
   import pci_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [SAMPLE_W-1:0]    rsp_tdata
);

   // a stalled result holds until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed or dropped");

   // reset empties the pipeline
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("result or backpressure right after reset");

   // input backpressure only while a parked result still waits
   a_park_held: assert property (@(posedge clock) disable iff (reset)
      !req_tready && !rsp_tready |=> !req_tready && rsp_tvalid)
      else $error("parked result released without a transfer");

   // taking the parked result reopens the input next cycle
   a_park_free: assert property (@(posedge clock) disable iff (reset)
      !req_tready && rsp_tready |=> req_tready)
      else $error("input stays blocked after parked result left");

endmodule

bind pressure_curve_interpolator pci_checker u_pci_checker (.*);

### verif/testbench.sv
// Self-checking testbench of the pressure curve interpolator: directed and random curves.
`timescale 1ns / 100ps

module testbench;
   import pci_pkg::*;

   // the block is built with its default breakpoint capacity
   localparam int CURVE_POINTS = MAX_POINTS_DEF;
   localparam int SAMPLE_MAX   = (1 << SAMPLE_W) - 1;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [SAMPLE_W-1:0]    req_tdata = '0;    // [15:0] raw_pressure
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [SAMPLE_W-1:0]    rsp_tdata;         // [15:0] curved_pressure
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   pressure_curve_interpolator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial forever #1 clock = ~clock;

   // Curve as the block holds it; updated on each register transfer.
   logic [COUNT_W-1:0] curve_count = COUNT_RESET;
   point_type          curve_point [REG_SLOTS];

   // Curve the stimulus wants next; also steers samples toward breakpoints.
   logic [COUNT_W-1:0] plan_count = COUNT_RESET;
   point_type          plan_point [REG_SLOTS];

   sample_type pending_q[$];    // raw samples waiting for the driver
   sample_type expected_q[$];   // mapped pressures not yet seen on rsp

   bit          send_steady = 1'b0;
   bit          recv_steady = 1'b0;
   int unsigned send_wait = 0;
   int unsigned recv_wait = 0;
   int          failures = 0;

   // Piecewise-linear mapping of one raw sample through the current curve.
   function automatic sample_type map_pressure(input sample_type raw);
      int unsigned n;
      int unsigned b;
      longint      p;
      longint      xa;
      longint      ya;
      longint      xb;
      longint      yb;
      longint      span;
      longint      y;
      p = raw;
      n = curve_count;
      if (n < COUNT_MIN) n = COUNT_MIN;        // too few points: use two
      if (n > CURVE_POINTS) n = CURVE_POINTS;
      for (b = 1; b < n; b++) begin
         xa = curve_point[b-1][31:16];
         ya = curve_point[b-1][15:0];
         xb = curve_point[b][31:16];
         yb = curve_point[b][15:0];
         if (p <= xb) begin
            // non-ascending x gives a span of zero or less: floor to one LSB
            span = xb - xa;
            if (span < 1) span = 1;
            // below the first x the offset is negative; division truncates toward zero
            y = ya + ((yb - ya) * (p - xa)) / span;
            if (y < 0) y = 0;
            if (y > SAMPLE_MAX) y = SAMPLE_MAX;
            return sample_type'(y);
         end
      end
      // past the last breakpoint in use: hold its y
      return curve_point[n-1][15:0];
   endfunction

   function automatic int unsigned draw_gap(input bit steady);
      return steady ? 0 : $urandom_range(0, 15);
   endfunction

   // Driver: feeds raw samples from pending_q; a random gap follows each unless send_steady.
   always @(posedge clock) begin : req_driver
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         send_wait  <= 0;
      end else begin
         // a transfer here fixes the expected result under the current curve
         if (req_tvalid && req_tready) expected_q.push_back(map_pressure(req_tdata));
         if (!req_tvalid || req_tready) begin
            if (send_wait != 0) begin
               send_wait  <= send_wait - 1;
               req_tvalid <= 1'b0;
            end else if (pending_q.size() != 0) begin
               req_tdata  <= pending_q.pop_front();
               req_tvalid <= 1'b1;
               send_wait  <= draw_gap(send_steady);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each rsp transfer against the oldest expectation, then
   // holds tready low for a random stall unless recv_steady is set.
   always @(posedge clock) begin : rsp_monitor
      int unsigned stall;
      sample_type  want;
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_wait  <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         if (expected_q.size() == 0) begin
            $error("curved_pressure: no result pending, actual %0d", rsp_tdata);
            failures++;
         end else begin
            want = expected_q.pop_front();
            if (rsp_tdata !== want) begin
               $error("curved_pressure: expected %0d, actual %0d", want, rsp_tdata);
               failures++;
            end
         end
         stall = draw_gap(recv_steady);
         recv_wait  <= stall;
         rsp_tready <= (stall == 0);
      end else if (recv_wait != 0) begin
         recv_wait  <= recv_wait - 1;
         rsp_tready <= (recv_wait == 1);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Writes point_count and all seven breakpoints back to back; valid stays high
   // across the burst and drops once after the last transfer.
   task automatic program_curve();
      int k;
      for (k = 0; k <= REG_SLOTS; k++) begin
         csr_valid <= 1'b1;
         if (k == 0) begin
            csr_index <= REG_POINT_COUNT;
            // junk above the count field must be dropped
            csr_data  <= ($urandom & ~32'h7) | 32'(plan_count);
         end else begin
            csr_index <= REG_POINT_BASE + CSR_INDEX_W'(k - 1);
            csr_data  <= plan_point[k-1];
         end
         do @(posedge clock); while (!csr_ready);
         if (k == 0) curve_count = plan_count;
         else curve_point[k-1] = plan_point[k-1];
      end
      csr_valid <= 1'b0;
   endtask

   // Random curve: mostly ascending x with random y, sometimes raw 32-bit noise.
   task automatic plan_random_curve(input int forced_count);
      int unsigned xs[$];
      int          k;
      plan_count = (forced_count >= 0) ? COUNT_W'(forced_count)
                                       : COUNT_W'($urandom_range(0, 7));
      if ($urandom_range(0, 4) == 0) begin
         for (k = 0; k < REG_SLOTS; k++) plan_point[k] = $urandom;
      end else begin
         xs = {};
         for (k = 0; k < REG_SLOTS; k++) xs.push_back($urandom_range(0, SAMPLE_MAX));
         xs.sort();
         if ($urandom_range(0, 2) == 0) begin
            xs[0] = 0;
            xs[REG_SLOTS-1] = SAMPLE_MAX;
         end
         for (k = 0; k < REG_SLOTS; k++) begin
            plan_point[k][31:16] = xs[k][15:0];
            if ($urandom_range(0, 3) == 0)
               plan_point[k][15:0] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            else
               plan_point[k][15:0] = 16'($urandom);
         end
      end
   endtask

   // Samples: uniform, close to a breakpoint x, the ends of the range.
   task automatic queue_random_samples(input int count);
      int k;
      int j;
      int p;
      for (k = 0; k < count; k++) begin
         case ($urandom_range(0, 7))
            0, 1, 2, 3: p = $urandom_range(0, SAMPLE_MAX);
            4, 5: begin
               j = $urandom_range(0, REG_SLOTS - 1);
               p = int'(plan_point[j][31:16]) + int'($urandom_range(0, 4)) - 2;
               if (p < 0) p = 0;
               if (p > SAMPLE_MAX) p = SAMPLE_MAX;
            end
            6: p = $urandom_range(0, 1) ? SAMPLE_MAX : 0;
            default: p = $urandom_range(0, 1) ? $urandom_range(0, 255)
                                              : $urandom_range(SAMPLE_MAX - 255, SAMPLE_MAX);
         endcase
         pending_q.push_back(sample_type'(p));
      end
   endtask

   // Returns once the driver is empty and every expected result has arrived.
   task automatic wait_drained();
      do @(posedge clock);
      while (pending_q.size() != 0 || req_tvalid || expected_q.size() != 0);
   endtask

   task automatic pick_idling();
      send_steady = ($urandom_range(0, 3) == 0);
      recv_steady = ($urandom_range(0, 3) == 0);
   endtask

   initial begin : stimulus
      int k;
      int ph;
      for (k = 0; k < REG_SLOTS; k++) begin
         curve_point[k] = POINT_RESET[k];
         plan_point[k]  = POINT_RESET[k];
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reset curve: ends of range and both sides of the knees.
      pick_idling();
      pending_q = '{16'h0000, 16'hFFFF, 16'h3FFF, 16'h4000, 16'h4001,
                    16'hBFFF, 16'hC000, 16'h8001};
      wait_drained();

      // Count of zero acts as two points; rising segment, so samples below
      // the first x extrapolate negative and clamp at zero.
      plan_count = 3'd0;
      plan_point = '{32'h1000_0800, 32'h2000_F000, 32'h1234_5678, 32'h0000_0000,
                     32'hFFFF_0000, 32'h8000_8000, 32'h0001_0001};
      program_curve();
      pick_idling();
      pending_q = '{16'h0000, 16'h0FFF, 16'h1800, 16'h2001, 16'hFFFF};
      wait_drained();

      // Count of one, falling segment: extrapolation below clamps at full scale.
      plan_count = 3'd1;
      plan_point = '{32'h4000_F000, 32'h5000_1000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
      program_curve();
      pick_idling();
      pending_q = '{16'h0000, 16'h4800, 16'h6000};
      wait_drained();

      // All seven points, with a repeated x and a step back in x; last x
      // below full scale so the tail holds the last y.
      plan_count = 3'd7;
      plan_point = '{32'h0000_0000, 32'h3000_2000, 32'h3000_9000, 32'h2000_4000,
                     32'h8000_A000, 32'hC000_1000, 32'hF000_FFFF};
      program_curve();
      pick_idling();
      pending_q = '{16'h3000, 16'h3001, 16'h9000, 16'hF800, 16'hFFFF};
      wait_drained();

      // Random curves; the first two pin the count at its legal extremes.
      for (ph = 0; ph < 12; ph++) begin
         plan_random_curve(ph == 0 ? 2 : (ph == 1 ? 7 : -1));
         program_curve();
         pick_idling();
         queue_random_samples(110);
         wait_drained();
      end

      // catch anything the block emits past the last expected result
      repeat (50) @(posedge clock);
      if (failures == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

   initial begin : watchdog
      #1_000_000;
      $display("testbench: FAIL");
      $finish;
   end

endmodule
